/* rtl/core/lzwd_pkg.sv */
// Package for the LZW code decoder: shared constants, types and the
// front-to-back command struct. No dependencies.
`default_nettype none
package lzwd_pkg;
    localparam int DICT_ENTRIES_DEF = 3840;
    localparam int CODE_BITS_DEF    = 12;
    localparam int BEAT_BYTES_DEF   = 64;
    localparam int LITERALS         = 256;
    localparam int SBUF_DEPTH       = 4096;
    localparam int CW               = 12;
    localparam int SBUF_AW          = 12;
    localparam int NUM_LANES        = 8;

    typedef struct packed {
        logic [CW-1:0] code;
    } t_cmd;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_RDRQ  = 7'b0000100,
        ST_RDWT  = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

/* rtl/core/lzwd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/lzwd_front.sv */
// Front end: accepts code words, masks them to CODE_BITS and queues them.
// Depends on lzwd_pkg.
`default_nettype none
module lzwd_front import lzwd_pkg::*; #(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [CW-1:0] i_code,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output t_cmd               o_cmd
);
    localparam logic [CW-1:0] MASK = CW'((1 << CODE_BITS) - 1);
    t_cmd r_q [2];
    logic r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp].code <= i_code & MASK;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lzwd_back.sv */
// Back end: dictionary walk, string buffer, dictionary update and beat output.
// Depends on lzwd_pkg and lzwd_ram.
`default_nettype none
module lzwd_back import lzwd_pkg::*; #(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int BEAT_BYTES   = BEAT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_status,
    output logic [6:0]         o_byte_count,
    output logic               o_last_beat,
    output logic [63:0]        o_lanes [NUM_LANES]
);
    localparam int DAW = $clog2(DICT_ENTRIES);
    localparam logic [CW-1:0] DENT = CW'(DICT_ENTRIES);
    localparam logic [SBUF_AW-1:0] POS0 = SBUF_AW'(SBUF_DEPTH - 2);
    localparam logic [SBUF_AW-1:0] POSL = SBUF_AW'(SBUF_DEPTH - 1);

    t_state r_st;
    logic [CW-1:0] r_code, r_c, r_next, r_prior;
    logic r_have, r_kwk;
    logic [SBUF_AW-1:0] r_pos, r_start, r_rd;
    logic [CW:0] r_len, r_done, r_reads;
    logic [7:0] r_first;
    logic [6:0] r_fill;
    logic r_fill_wait;

    logic [7:0] r_beat [BEAT_BYTES];
    logic r_ov, r_ost, r_olast;
    logic [6:0] r_ocnt;

    logic d_we;
    logic [DAW-1:0] d_waddr, d_raddr;
    logic [CW-1:0] pre_rd;
    logic [7:0] suf_rd, sb_rd;
    logic sb_we;
    logic [SBUF_AW-1:0] sb_wa;
    logic [7:0] sb_wd;
    logic [CW-1:0] idx;

    assign idx = r_c - CW'(LITERALS);
    assign d_raddr = idx[DAW-1:0];

    lzwd_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_pre (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(r_prior),
        .i_raddr(d_raddr), .o_rdata(pre_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suf (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(r_c[7:0]),
        .i_raddr(d_raddr), .o_rdata(suf_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(SBUF_DEPTH)) u_sb (
        .i_clk, .i_we(sb_we), .i_waddr(sb_wa), .i_wdata(sb_wd),
        .i_raddr(r_rd), .o_rdata(sb_rd));

    assign o_cmd_ready = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_byte_count = r_ocnt;
    assign o_last_beat = r_olast;
    always_comb begin
        for (int i = 0; i < BEAT_BYTES; i++) begin
            o_lanes[i/8][(i%8)*8 +: 8] = r_beat[i];
        end
    end

    logic [CW:0] remain;
    logic [6:0] beat_n;
    assign remain = r_len - r_done;
    assign beat_n = (remain > (CW+1)'(BEAT_BYTES)) ? 7'(BEAT_BYTES) : remain[6:0];

    always_comb begin
        sb_we = 1'b0; sb_wa = r_pos; sb_wd = suf_rd;
        d_we = 1'b0; d_waddr = r_next[DAW-1:0];
        case (r_st)
            ST_RDWT: begin sb_we = 1'b1; end
            ST_FIN: begin
                sb_we = 1'b1; sb_wd = r_c[7:0];
                d_we = r_have && (r_next < DENT);
            end
            ST_FILL: begin
                if (r_kwk) begin sb_we = 1'b1; sb_wa = POSL; sb_wd = r_first; end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0; r_have <= 1'b0;
            r_next <= '0; r_prior <= '0;
        end else begin
            if (i_ready && r_ov) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: if (i_cmd_valid) begin
                    r_code <= i_cmd.code; r_st <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_pos <= POS0; r_reads <= '0; r_kwk <= 1'b0;
                    if (!r_have) begin
                        if (r_code > CW'(255)) begin
                            r_st <= ST_EMIT;
                        end else begin
                            r_c <= r_code; r_st <= ST_FIN;
                        end
                    end else if (r_code < CW'(LITERALS) + r_next) begin
                        r_c <= r_code; r_st <= ST_RDRQ;
                    end else if (r_code == CW'(LITERALS) + r_next) begin
                        r_c <= r_prior; r_kwk <= 1'b1; r_st <= ST_RDRQ;
                    end else begin
                        r_st <= ST_EMIT;
                    end
                end
                ST_RDRQ: begin
                    if (r_c <= CW'(255)) r_st <= ST_FIN;
                    else if (r_reads >= (CW+1)'(DICT_ENTRIES) || idx >= DENT) begin
                        r_st <= ST_EMIT;
                    end else r_st <= ST_RDWT;
                end
                ST_RDWT: begin
                    r_pos <= r_pos - 1'b1; r_c <= pre_rd;
                    r_reads <= r_reads + 1'b1; r_st <= ST_RDRQ;
                end
                ST_FIN: begin
                    r_first <= r_c[7:0];
                    r_fill <= '0; r_fill_wait <= 1'b1; r_done <= '0;
                    if (!r_have) begin
                        r_start <= POS0; r_len <= (CW+1)'(1);
                        r_prior <= r_code; r_have <= 1'b1;
                    end else begin
                        r_start <= r_pos;
                        r_len <= (CW+1)'(SBUF_DEPTH) - {1'b0, r_pos}
                                 - (r_kwk ? '0 : (CW+1)'(1));
                        if (r_next + 1'b1 >= DENT) begin
                            r_prior <= {4'd0, r_c[7:0]}; r_next <= '0;
                        end else begin
                            r_prior <= r_code; r_next <= r_next + 1'b1;
                        end
                    end
                    r_rd <= r_pos;
                    r_st <= ST_FILL;
                end
                ST_FILL: if (!r_ov) begin
                    // the wait step before each beat clears it and lets the KwKwK tail byte land before reads
                    if (r_fill_wait) begin
                        r_fill_wait <= 1'b0; r_rd <= r_rd + 1'b1;
                        for (int i = 0; i < BEAT_BYTES; i++) r_beat[i] <= 8'd0;
                    end else begin
                        if (7'(r_fill) < beat_n) r_beat[r_fill[5:0]] <= sb_rd;
                        if (r_fill + 1'b1 >= beat_n) begin
                            r_ov <= 1'b1; r_ost <= 1'b0; r_ocnt <= beat_n;
                            r_olast <= (remain == (CW+1)'(beat_n));
                            r_done <= r_done + (CW+1)'(beat_n);
                            r_fill <= '0;
                            r_rd <= r_start + SBUF_AW'(r_done) + SBUF_AW'(beat_n);
                            r_fill_wait <= 1'b1;
                            if (remain == (CW+1)'(beat_n)) r_st <= ST_IDLE;
                        end else begin
                            r_fill <= r_fill + 1'b1; r_rd <= r_rd + 1'b1;
                        end
                    end
                end
                ST_EMIT: if (!r_ov) begin
                    r_ov <= 1'b1; r_ost <= 1'b1; r_ocnt <= '0; r_olast <= 1'b1;
                    for (int i = 0; i < BEAT_BYTES; i++) r_beat[i] <= 8'd0;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lzw_code_decoder.sv */
// Top level of the LZW code decoder: front queue plus back-end walker.
// Depends on lzwd_pkg, lzwd_front, lzwd_back.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | i_code
//  out     | output    | o_valid / i_ready  | o_status, o_byte_count, o_last_beat, lanes
//
// A code is taken from the queue into the check state, then walks the dictionary
// link by link (the first code needs no walk) before the final state; each beat
// is then filled byte by byte from the string buffer. The
// dictionary read port sets the walk rate and the string buffer read port the fill rate.
// A corrupt code leaves as one word after the check or the failed walk, once the output is free.
// Reset (synchronous, active low) clears control; dictionary is undefined.
// Filling a beat waits while the previous word is held at the output; the
// two-entry input queue accepts codes while the back end is busy.
`default_nettype none
module lzw_code_decoder import lzwd_pkg::*; #(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF,
    parameter int BEAT_BYTES   = BEAT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [CW-1:0] i_code,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_status,
    output logic [6:0]         o_byte_count,
    output logic               o_last_beat,
    output logic [63:0]        o_bytes_lane0,
    output logic [63:0]        o_bytes_lane1,
    output logic [63:0]        o_bytes_lane2,
    output logic [63:0]        o_bytes_lane3,
    output logic [63:0]        o_bytes_lane4,
    output logic [63:0]        o_bytes_lane5,
    output logic [63:0]        o_bytes_lane6,
    output logic [63:0]        o_bytes_lane7
);
    logic cmd_valid, cmd_ready;
    t_cmd cmd;
    logic [63:0] lanes [NUM_LANES];

    lzwd_front #(.CODE_BITS(CODE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_code,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd));

    lzwd_back #(.DICT_ENTRIES(DICT_ENTRIES), .BEAT_BYTES(BEAT_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .o_valid, .i_ready, .o_status, .o_byte_count,
        .o_last_beat, .o_lanes(lanes));

    assign o_bytes_lane0 = lanes[0];
    assign o_bytes_lane1 = lanes[1];
    assign o_bytes_lane2 = lanes[2];
    assign o_bytes_lane3 = lanes[3];
    assign o_bytes_lane4 = lanes[4];
    assign o_bytes_lane5 = lanes[5];
    assign o_bytes_lane6 = lanes[6];
    assign o_bytes_lane7 = lanes[7];
endmodule
`default_nettype wire

/* rtl/core/lzwd_checker.sv */
// Port-level checker for the LZW code decoder, bound to the top level.
// Depends on lzwd_pkg.
`default_nettype none
module lzwd_checker import lzwd_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_status,
    input wire logic [6:0] o_byte_count,
    input wire logic o_last_beat
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_count))
        else $error("beat dropped while stalled");
    a_corrupt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last_beat && o_byte_count == 7'd0)
        else $error("corrupt beat malformed");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_byte_count != 7'd0 && o_byte_count <= 7'd64)
        else $error("bad byte count");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status && !o_last_beat |-> o_byte_count == 7'd64)
        else $error("short non-final beat");
endmodule
bind lzw_code_decoder lzwd_checker u_chk (.*);
`default_nettype wire
